[hdl/lss_pkg.sv]
// lss_pkg: shared types and codes for the lifo stack with search
// used by lifo_stack_search_core, lss_ctrl and the checker
// no dependencies

package lss_pkg;

    // operation codes carried in the func field
    localparam logic [1:0] FN_PUSH   = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_SEARCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    // one request item
    typedef struct packed {
        logic [1:0]               func;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped;
        logic                     found;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

endpackage

[hdl/lifo_stack_search_core.sv]
// lifo_stack_search_core: top level of the bounded lifo stack with search
// depends on lss_pkg, lss_ctrl and lss_ram

// A bounded last-in-first-out stack of STACK_DEPTH signed 32-bit words held
// in a single-port-read ram, taking one request item at a time. A push goes
// straight from acceptance to the result state, a pop via the pop state and a
// search via the scan state, comparing 1 up to the fill count of entries (at
// most STACK_DEPTH): one comparator checks one ram word per cycle from the top
// down and stops at the first match. Requests on empty or full stacks and the
// unused func code go straight to the result state. A finished result sits in
// an output register so the next request can be accepted while it waits.
// Occupancy reports the low 5 bits of the fill count. No clearing pass is
// needed after reset: the stack starts empty and only pushed words are read.

module lifo_stack_search_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lss_pkg::t_out_item o_out_item
);

    logic               busy;
    logic               res_valid;
    lss_pkg::t_out_item res;
    logic               res_take;
    logic               r_out_valid;
    lss_pkg::t_out_item r_out_item;

    lss_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // output register takes a result when empty or being drained
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/lss_ram.sv]
// lss_ram: generic single-write, single-read ram with registered read data
// no package dependencies

module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/lss_ctrl.sv]
// lss_ctrl: request sequencer, fill count and the shared key comparator
// depends on lss_pkg and lss_ram

module lss_ctrl #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lss_pkg::t_in_item i_in_item,
    output logic              o_busy,
    output logic              o_res_valid,
    output lss_pkg::t_out_item o_res,
    input  logic              i_res_take
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);

    lss_pkg::t_state r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_idx, n_idx;
    logic signed [lss_pkg::WORD_W-1:0] r_key, n_key;
    logic signed [lss_pkg::WORD_W-1:0] r_popped, n_popped;
    logic [1:0]      r_status, n_status;
    logic            r_found, n_found;

    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [lss_pkg::WORD_W-1:0]   rd_data;
    logic [FW-1:0]                fill_m1;
    logic [AW-1:0]                idx_m1;
    logic                         full;
    logic                         empty;
    logic                         hit;

    assign fill_m1 = r_fill - 1'b1;
    assign idx_m1  = r_idx - 1'b1;
    assign full    = (r_fill == FW'(STACK_DEPTH));
    assign empty   = (r_fill == '0);

    // shared comparator: one stored entry against the key per cycle
    assign hit = (rd_data == r_key);

    lss_ram #(
        .WIDTH (lss_pkg::WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_in_item.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_key    = r_key;
        n_popped = r_popped;
        n_status = r_status;
        n_found  = r_found;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = fill_m1[AW-1:0];
        unique case (r_state)
            lss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_in_item.value;
                    n_popped = '0;
                    n_found  = 1'b0;
                    n_status = lss_pkg::ST_DONE;
                    n_state  = lss_pkg::S_RESP;
                    priority if (i_in_item.func == lss_pkg::FN_PUSH) begin
                        if (full) begin
                            n_status = lss_pkg::ST_FULL;
                        end else begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end else if (i_in_item.func == lss_pkg::FN_POP) begin
                        if (empty) begin
                            n_status = lss_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            n_fill  = fill_m1;
                            n_state = lss_pkg::S_POP;
                        end
                    end else if (i_in_item.func == lss_pkg::FN_SEARCH) begin
                        if (empty) begin
                            n_status = lss_pkg::ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            n_idx   = fill_m1[AW-1:0];
                            n_state = lss_pkg::S_SCAN;
                        end
                    end else begin
                        // unused code: no operation
                        n_status = lss_pkg::ST_DONE;
                    end
                end
            end
            lss_pkg::S_POP: begin
                n_popped = rd_data;
                n_state  = lss_pkg::S_RESP;
            end
            lss_pkg::S_SCAN: begin
                // walk from the top entry down to entry 0
                if (hit) begin
                    n_found = 1'b1;
                    n_state = lss_pkg::S_RESP;
                end else if (r_idx == '0) begin
                    n_state = lss_pkg::S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m1;
                    n_idx   = idx_m1;
                end
            end
            lss_pkg::S_RESP: begin
                if (i_res_take) begin
                    n_state = lss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lss_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_popped <= n_popped;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_busy           = (r_state != lss_pkg::S_IDLE);
    assign o_res_valid      = (r_state == lss_pkg::S_RESP);
    assign o_res.status     = r_status;
    assign o_res.popped     = r_popped;
    assign o_res.found      = r_found;
    assign o_res.occupancy  = lss_pkg::OCC_W'(r_fill);

endmodule

[hdl/lss_checker.sv]
// lss_checker: port-level assertions for lifo_stack_search_core
// depends on lss_pkg; bound to the top level at the end of this file

module lss_checker #(
    parameter int STACK_DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lss_pkg::t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    // one request at a time: busy right after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous one still in work");

    // found only on a completed search, never with a popped word
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |->
            o_out_item.status == lss_pkg::ST_DONE && o_out_item.popped == '0)
        else $error("found flag with bad status or popped word");

    // empty result implies nothing held and nothing popped
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == lss_pkg::ST_EMPTY |->
            o_out_item.occupancy == '0 && o_out_item.popped == '0)
        else $error("empty status with nonzero occupancy or popped word");

    // refused push only when the stack is at full depth
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == lss_pkg::ST_FULL |->
            o_out_item.occupancy == lss_pkg::OCC_W'(STACK_DEPTH))
        else $error("full status below full depth");

endmodule

bind lifo_stack_search_core lss_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_lss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
